### sv/pfe_pkg.sv
// shared types and constants for the postfix expression evaluator
package pfe_pkg;

  // width of the reported result field
  localparam int VALUE_W = 16;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_UNDER   = 3'd2;
  localparam logic [2:0] ST_OVER    = 3'd3;
  localparam logic [2:0] ST_DIVZERO = 3'd4;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  // move of one stack cell per cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_DOWN,
    CELL_UP
  } cell_op_t;

  // request to the multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  // input item
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [2:0]                status;
    logic                      has_value;
    logic signed [VALUE_W-1:0] value;
  } out_item_t;

endpackage

### sv/pfe_cell.sv
// one stack entry: holds, takes from the entry above or from the entry below
module pfe_cell #(
  parameter int WIDTH = 16
) (
  input  logic              clk,
  input  pfe_pkg::cell_op_t op,
  input  logic [WIDTH-1:0]  from_above,
  input  logic [WIDTH-1:0]  from_below,
  output logic [WIDTH-1:0]  q
);

  logic [WIDTH-1:0] q_r;
  logic [WIDTH-1:0] q_nxt;

  // neighbor select
  always_comb begin
    case (op)
      pfe_pkg::CELL_DOWN: q_nxt = from_above;
      pfe_pkg::CELL_UP:   q_nxt = from_below;
      default:            q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

### sv/pfe_muldiv.sv
// bit-serial multiplier and signed truncating divider, one bit per cycle
module pfe_muldiv #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pfe_pkg::md_req_t req,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  localparam int CNT_W = $clog2(WIDTH);

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_RUN,
    MD_FIX
  } md_state_t;

  md_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             is_div_r, is_div_nxt;
  logic             neg_r, neg_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;       // product accumulator
  logic [WIDTH-1:0] mcand_r, mcand_nxt;   // multiplicand, or divisor magnitude
  logic [WIDTH-1:0] mplier_r, mplier_nxt; // multiplier, or dividend/quotient
  logic [WIDTH:0]   rem_r, rem_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH-1:0] result_r, result_nxt;

  logic [WIDTH-1:0] a_mag;
  logic [WIDTH-1:0] b_mag;
  logic [WIDTH:0]   rem_sh;

  assign a_mag  = a[WIDTH-1] ? (~a + 1'b1) : a;
  assign b_mag  = b[WIDTH-1] ? (~b + 1'b1) : b;
  assign rem_sh = {rem_r[WIDTH-1:0], mplier_r[WIDTH-1]};

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    is_div_nxt = is_div_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    rem_nxt    = rem_r;
    done_nxt   = 1'b0;
    result_nxt = result_r;
    case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          state_nxt  = MD_RUN;
          cnt_nxt    = CNT_W'(WIDTH - 1);
          is_div_nxt = req.is_div;
          neg_nxt    = a[WIDTH-1] ^ b[WIDTH-1];
          acc_nxt    = '0;
          rem_nxt    = '0;
          // low bits of the product do not depend on sign
          mcand_nxt  = req.is_div ? b_mag : a;
          mplier_nxt = req.is_div ? a_mag : b;
        end
      end
      MD_RUN: begin
        if (is_div_r) begin
          // restoring step: shift in next dividend bit, subtract if it fits
          mplier_nxt = {mplier_r[WIDTH-2:0], 1'b0};
          if (rem_sh >= {1'b0, mcand_r}) begin
            rem_nxt       = rem_sh - {1'b0, mcand_r};
            mplier_nxt[0] = 1'b1;
          end else begin
            rem_nxt = rem_sh;
          end
        end else begin
          // shift-add step
          if (mplier_r[0]) begin
            acc_nxt = acc_r + mcand_r;
          end
          mcand_nxt  = {mcand_r[WIDTH-2:0], 1'b0};
          mplier_nxt = {1'b0, mplier_r[WIDTH-1:1]};
        end
        if (cnt_r == '0) begin
          state_nxt = MD_FIX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      MD_FIX: begin
        // quotient sign fix; a product is passed on as it is
        if (is_div_r) begin
          result_nxt = neg_r ? (~mplier_r + 1'b1) : mplier_r;
        end else begin
          result_nxt = acc_r;
        end
        done_nxt  = 1'b1;
        state_nxt = MD_IDLE;
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r    <= cnt_nxt;
    is_div_r <= is_div_nxt;
    neg_r    <= neg_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    rem_r    <= rem_nxt;
    result_r <= result_nxt;
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

### sv/postfix_expression_evaluator.sv
// top level: postfix expression evaluator over a chain of stack cells
// Each input item is one character of a postfix expression; each item gives exactly one
// result item. The operand stack is a row of DEPTH cells, the top entry in cell 0: a push
// shifts every cell down by one, an operator shifts cells 1 and below up and writes its result
// into cell 0. Items are taken one at a time. Digits, letters, other characters, '+' and '-'
// pass from acceptance through the execute and done states to the result register; '*' and '/'
// also wait for the shared bit-serial multiply/divide unit that retires one bit per cycle. A new
// item is accepted from the cycle after the previous one has reached the result register;
// a stalled result holds the input off until the result register frees up. The stack
// needs no clearing after reset; entry count starts at zero.
module postfix_expression_evaluator #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pfe_pkg::out_item_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [7:0]         ch_r, ch_nxt;
  logic               last_r, last_nxt;
  logic [2:0]         status_r, status_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  pfe_pkg::out_item_t out_data_r, out_data_nxt;

  // stack chain
  logic [WIDTH-1:0]   cell_q [DEPTH];
  pfe_pkg::cell_op_t  top_op;
  pfe_pkg::cell_op_t  rest_op;
  logic [WIDTH-1:0]   top_load;

  pfe_pkg::md_req_t   md_req;
  logic               md_done;
  logic [WIDTH-1:0]   md_result;

  logic               is_digit;
  logic               is_letter;
  logic               is_op;
  logic               out_free;
  logic               out_load;
  logic [WIDTH-1:0]   opa;
  logic [WIDTH-1:0]   opb;
  logic signed [WIDTH-1:0] top_s;

  assign opa   = cell_q[1];
  assign opb   = cell_q[0];
  assign top_s = signed'(cell_q[0]);

  // character class
  assign is_digit  = (ch_r >= pfe_pkg::CH_ZERO) && (ch_r <= pfe_pkg::CH_NINE);
  assign is_letter = ((ch_r >= pfe_pkg::CH_UP_A) && (ch_r <= pfe_pkg::CH_UP_Z)) ||
                     ((ch_r >= pfe_pkg::CH_LO_A) && (ch_r <= pfe_pkg::CH_LO_Z));
  assign is_op     = (ch_r == pfe_pkg::CH_PLUS) || (ch_r == pfe_pkg::CH_MINUS) ||
                     (ch_r == pfe_pkg::CH_STAR) || (ch_r == pfe_pkg::CH_SLASH);

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_DONE) && out_free;

  // row of stack cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] above;
    logic [WIDTH-1:0] below;
    if (i == 0) begin : g_top
      assign above = top_load;
    end else begin : g_above
      assign above = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_bottom
      assign below = '0;
    end else begin : g_below
      assign below = cell_q[i+1];
    end
    pfe_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk        (clk),
      .op         ((i == 0) ? top_op : rest_op),
      .from_above (above),
      .from_below (below),
      .q          (cell_q[i])
    );
  end

  pfe_muldiv #(
    .WIDTH (WIDTH)
  ) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .a      (opa),
    .b      (opb),
    .done   (md_done),
    .result (md_result)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    last_nxt      = last_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    top_op        = pfe_pkg::CELL_HOLD;
    rest_op       = pfe_pkg::CELL_HOLD;
    top_load      = '0;
    md_req.start  = 1'b0;
    md_req.is_div = (ch_r == pfe_pkg::CH_SLASH);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ch_nxt     = in_data.ch;
          last_nxt   = in_data.last;
          status_nxt = pfe_pkg::ST_OK;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        if (is_digit) begin
          if (count_r >= CNT_W'(DEPTH)) begin
            status_nxt = pfe_pkg::ST_OVER;
          end else begin
            top_op    = pfe_pkg::CELL_DOWN;
            rest_op   = pfe_pkg::CELL_DOWN;
            top_load  = WIDTH'(ch_r - pfe_pkg::CH_ZERO);
            count_nxt = count_r + 1'b1;
          end
        end else if (is_letter) begin
          status_nxt = pfe_pkg::ST_INVALID;
        end else if (is_op) begin
          if (count_r < CNT_W'(2)) begin
            status_nxt = pfe_pkg::ST_UNDER;
          end else if (ch_r == pfe_pkg::CH_PLUS || ch_r == pfe_pkg::CH_MINUS) begin
            top_op    = pfe_pkg::CELL_DOWN;
            rest_op   = pfe_pkg::CELL_UP;
            top_load  = (ch_r == pfe_pkg::CH_PLUS) ? (opa + opb) : (opa - opb);
            count_nxt = count_r - 1'b1;
          end else if (ch_r == pfe_pkg::CH_SLASH && opb == '0) begin
            status_nxt = pfe_pkg::ST_DIVZERO;
          end else begin
            md_req.start = 1'b1;
            state_nxt    = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        // pop both operands, push the unit's result
        if (md_done) begin
          top_op    = pfe_pkg::CELL_DOWN;
          rest_op   = pfe_pkg::CELL_UP;
          top_load  = md_result;
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = status_r;
          out_data_nxt.has_value = 1'b0;
          out_data_nxt.value     = '0;
          if (last_r) begin
            if (count_r == '0) begin
              if (status_r == pfe_pkg::ST_OK) begin
                out_data_nxt.status = pfe_pkg::ST_UNDER;
              end
            end else begin
              out_data_nxt.has_value = 1'b1;
              out_data_nxt.value     = pfe_pkg::VALUE_W'(top_s);
            end
            count_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ch_r       <= ch_nxt;
    last_r     <= last_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above stack depth");

  a_md_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> state_r == S_WAIT)
    else $error("multiply/divide result outside wait state");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && last_r |=> count_r == '0)
    else $error("stack not emptied after last item");

  a_no_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_value |-> out_data.value == '0)
    else $error("value nonzero without a result");

endmodule

### verif/tb_postfix_expression_evaluator.sv
// testbench for the postfix expression evaluator: directed table, random expressions, scoreboard
module tb_postfix_expression_evaluator;

  localparam int STACK_DEPTH = 32;
  localparam int DATA_W = 16;
  localparam int ITEMS_TOTAL = 1375;
  localparam int HOLD_CYCLES = 200;
  localparam int SCRIPT_LEN = 25;

  // shapes of generated expressions
  typedef enum logic [1:0] {
    EXPR_WELL,
    EXPR_DEEP,
    EXPR_BROKEN,
    EXPR_NOISE
  } expr_style_t;

  // one row of the directed table; res is used only when typed is set
  typedef struct packed {
    pfe_pkg::in_item_t  item;
    logic               typed;
    pfe_pkg::out_item_t res;
  } script_row_t;

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{'{"5", 1'b1}, 1'b1, '{pfe_pkg::ST_OK, 1'b1, 16'sd5}},
    '{'{"A", 1'b0}, 1'b1, '{pfe_pkg::ST_INVALID, 1'b0, 16'sd0}},
    '{'{pfe_pkg::CH_PLUS, 1'b0}, 1'b1, '{pfe_pkg::ST_UNDER, 1'b0, 16'sd0}},
    '{'{" ", 1'b1}, 1'b1, '{pfe_pkg::ST_UNDER, 1'b0, 16'sd0}},
    '{'{"9", 1'b0}, 1'b0, '0},
    '{'{"0", 1'b0}, 1'b0, '0},
    '{'{pfe_pkg::CH_SLASH, 1'b0}, 1'b1, '{pfe_pkg::ST_DIVZERO, 1'b0, 16'sd0}},
    '{'{pfe_pkg::CH_MINUS, 1'b0}, 1'b0, '0},
    '{'{8'hFF, 1'b1}, 1'b1, '{pfe_pkg::ST_OK, 1'b1, 16'sd9}},
    // 8^5 wraps to the most negative value, then divided by minus one
    '{'{"8", 1'b0}, 1'b0, '0},
    '{'{"8", 1'b0}, 1'b0, '0},
    '{'{pfe_pkg::CH_STAR, 1'b0}, 1'b0, '0},
    '{'{"8", 1'b0}, 1'b0, '0},
    '{'{pfe_pkg::CH_STAR, 1'b0}, 1'b0, '0},
    '{'{"8", 1'b0}, 1'b0, '0},
    '{'{pfe_pkg::CH_STAR, 1'b0}, 1'b0, '0},
    '{'{"8", 1'b0}, 1'b0, '0},
    '{'{pfe_pkg::CH_STAR, 1'b0}, 1'b0, '0},
    '{'{"0", 1'b0}, 1'b0, '0},
    '{'{"1", 1'b0}, 1'b0, '0},
    '{'{pfe_pkg::CH_MINUS, 1'b0}, 1'b0, '0},
    '{'{pfe_pkg::CH_SLASH, 1'b1}, 1'b1, '{pfe_pkg::ST_OK, 1'b1, 16'sh8000}},
    // error on the last item still reports the top of the stack
    '{'{"7", 1'b0}, 1'b0, '0},
    '{'{"z", 1'b1}, 1'b1, '{pfe_pkg::ST_INVALID, 1'b1, 16'sd7}},
    '{'{8'h00, 1'b1}, 1'b1, '{pfe_pkg::ST_UNDER, 1'b0, 16'sd0}}
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  pfe_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  pfe_pkg::out_item_t out_data;

  // predictor state
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned       stack_cnt;

  pfe_pkg::out_item_t pending_results [$];
  pfe_pkg::out_item_t oldest;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_reqs = 0;

  postfix_expression_evaluator #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(DATA_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  // evaluate one character against the predicted stack
  function automatic pfe_pkg::out_item_t eval_char(input pfe_pkg::in_item_t it);
    pfe_pkg::out_item_t r;
    logic [DATA_W-1:0]  a, b, q;
    logic               is_op, is_letter;
    r = '0;
    r.status = pfe_pkg::ST_OK;
    is_op = (it.ch == pfe_pkg::CH_PLUS) || (it.ch == pfe_pkg::CH_MINUS) ||
            (it.ch == pfe_pkg::CH_STAR) || (it.ch == pfe_pkg::CH_SLASH);
    is_letter = (it.ch >= pfe_pkg::CH_UP_A && it.ch <= pfe_pkg::CH_UP_Z) ||
                (it.ch >= pfe_pkg::CH_LO_A && it.ch <= pfe_pkg::CH_LO_Z);
    if (it.ch >= pfe_pkg::CH_ZERO && it.ch <= pfe_pkg::CH_NINE) begin
      if (stack_cnt >= STACK_DEPTH) begin
        r.status = pfe_pkg::ST_OVER;
      end else begin
        stack_mem[stack_cnt] = DATA_W'(it.ch - pfe_pkg::CH_ZERO);
        stack_cnt++;
      end
    end else if (is_letter) begin
      r.status = pfe_pkg::ST_INVALID;
    end else if (is_op) begin
      if (stack_cnt < 2) begin
        r.status = pfe_pkg::ST_UNDER;
      end else begin
        a = stack_mem[stack_cnt - 2];
        b = stack_mem[stack_cnt - 1];
        case (it.ch)
          pfe_pkg::CH_PLUS: q = a + b;
          pfe_pkg::CH_MINUS: q = a - b;
          pfe_pkg::CH_STAR: q = a * b;
          default: begin
            // truncating division, wrapped back to the stack width
            q = (b == '0) ? '0 : DATA_W'(longint'($signed(a)) / longint'($signed(b)));
          end
        endcase
        if (it.ch == pfe_pkg::CH_SLASH && b == '0) begin
          r.status = pfe_pkg::ST_DIVZERO;
        end else begin
          stack_cnt--;
          stack_mem[stack_cnt - 1] = q;
        end
      end
    end
    // end of expression: report top and empty the stack
    if (it.last) begin
      if (stack_cnt == 0) begin
        if (r.status == pfe_pkg::ST_OK) r.status = pfe_pkg::ST_UNDER;
      end else begin
        r.has_value = 1'b1;
        r.value = pfe_pkg::VALUE_W'(longint'($signed(stack_mem[stack_cnt - 1])));
      end
      stack_cnt = 0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // offer one item, wait for its acceptance and record the expected result
  task automatic send_item(input pfe_pkg::in_item_t it, input logic typed,
                           input pfe_pkg::out_item_t typed_res);
    pfe_pkg::out_item_t predicted;
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = eval_char(it);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  // one random expression, mostly well formed
  task automatic play_expr(input int unsigned roll);
    expr_style_t       style;
    int unsigned       operands, pushed, depth, k;
    pfe_pkg::in_item_t it;
    if (roll < 65) style = EXPR_WELL;
    else if (roll < 77) style = EXPR_DEEP;
    else if (roll < 90) style = EXPR_BROKEN;
    else style = EXPR_NOISE;
    if (style == EXPR_NOISE) begin
      for (k = $urandom_range(1, 6); k != 0; k--) begin
        it.ch = 8'($urandom_range(0, 255));
        it.last = 1'($urandom_range(0, 1));
        send_item(it, 1'b0, '0);
      end
    end else begin
      // deep expressions push all operands before reducing, at times past the stack size
      operands = (style == EXPR_DEEP) ? $urandom_range(28, 36) : $urandom_range(1, 10);
      pushed = 0;
      depth = 0;
      while (pushed < operands || depth > 1) begin
        if (pushed < operands &&
            (depth < 2 || style == EXPR_DEEP || $urandom_range(0, 1) == 1)) begin
          it.ch = pfe_pkg::CH_ZERO + 8'($urandom_range(0, 9));
          pushed++;
          depth++;
        end else begin
          case ($urandom_range(0, 3))
            0: it.ch = pfe_pkg::CH_PLUS;
            1: it.ch = pfe_pkg::CH_MINUS;
            2: it.ch = pfe_pkg::CH_STAR;
            default: it.ch = pfe_pkg::CH_SLASH;
          endcase
          depth--;
        end
        it.last = (pushed == operands && depth <= 1);
        // broken sequences: stray characters and early ends
        if (style == EXPR_BROKEN && $urandom_range(0, 99) < 20) begin
          case ($urandom_range(0, 3))
            0: it.ch = ($urandom_range(0, 1) ? pfe_pkg::CH_UP_A : pfe_pkg::CH_LO_A) +
                       8'($urandom_range(0, 25));
            1: it.ch = $urandom_range(0, 1) ? pfe_pkg::CH_SLASH : pfe_pkg::CH_MINUS;
            2: it.ch = 8'($urandom_range(0, 255));
            default: it.ch = pfe_pkg::CH_ZERO + 8'($urandom_range(0, 9));
          endcase
        end
        if (style == EXPR_BROKEN && $urandom_range(0, 99) < 4) it.last = 1'b1;
        send_item(it, 1'b0, '0);
      end
    end
  endtask

  // result side: random stalls and one long hold-off on request
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
        out_stall = 1'b0;
      end else begin
        out_stall = (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: status %0d has_value %0d value %0d",
                                out_data.status, out_data.has_value, out_data.value));
      end else begin
        oldest = pending_results.pop_front();
        if (out_data.status !== oldest.status || out_data.has_value !== oldest.has_value ||
            out_data.value !== oldest.value) begin
          flag_mismatch($sformatf("status %0d has_value %0d value %0d, wanted %0d %0d %0d",
                                  out_data.status, out_data.has_value, out_data.value,
                                  oldest.status, oldest.has_value, oldest.value));
        end
      end
    end
  end

  // main sequence
  initial begin
    int unsigned row, waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idle_pct = 13;
    stall_pct = 13;
    stack_cnt = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    for (row = 0; row < SCRIPT_LEN; row++) begin
      send_item(SCRIPT[row].item, SCRIPT[row].typed, SCRIPT[row].res);
    end

    // stretch with no idling on either side
    idle_pct = 0;
    stall_pct = 0;
    while (items_sent < 325) play_expr($urandom_range(0, 99));

    // receiver holds off while items keep coming, so the block backs up
    idle_pct = 13;
    stall_pct = 13;
    hold_reqs++;
    while (items_sent < 450) play_expr($urandom_range(0, 99));

    // sender pauses until every result is in
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    while (items_sent < ITEMS_TOTAL) play_expr($urandom_range(0, 99));
    @(negedge clk);
    in_valid = 1'b0;

    // drain, then watch for stray results
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
